// ===== sv/sorted_set_intersection_unit_assert.svh =====
// Assertion macros for the sorted set intersection unit; the join controller includes them.
// With SYNTHESIS defined the macros expand to nothing.
`ifndef SORTED_SET_INTERSECTION_UNIT_ASSERT_SVH
`define SORTED_SET_INTERSECTION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SSI_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

`define SSI_ASSERT(label, prop) `SSI_ASSERT_CLK(label, clock, reset, prop)

`else

`define SSI_ASSERT_CLK(label, clk, rst, prop)

`define SSI_ASSERT(label, prop)

`endif

`endif

// ===== sv/ssi_pkg.sv =====
package ssi_pkg;

   localparam int SET_DEPTH = 32;
   localparam int OUT_LIMIT = 32;
   localparam int VALUE_W   = 32;
   localparam int OP_W      = 2;
   localparam int CNT_W     = $clog2(SET_DEPTH + 1);
   localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int NUM_W     = $clog2(OUT_LIMIT + 1);

   typedef logic [OP_W-1:0]           op_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [NUM_W-1:0]          num_type;

   localparam op_type OP_LOAD_FIRST  = 2'd0;
   localparam op_type OP_LOAD_SECOND = 2'd1;
   localparam op_type OP_RUN         = 2'd2;

   typedef struct packed {
      value_type common_value;
      logic      found;
      logic      last;
      logic      overflow;
   } result_type;

   typedef struct packed {
      logic       load;
      result_type data;
   } result_load_type;

   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      value_type wr_data;
      addr_type  rd_addr;
   } ram_ctrl_type;

endpackage

// ===== sv/ssi_if.sv =====
interface ssi_req_if;
   import ssi_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   value_type value;

   modport source (output valid, output operation, output value, input ready);
   modport sink (input valid, input operation, input value, output ready);
endinterface

interface ssi_rsp_if;
   import ssi_pkg::*;

   logic      valid;
   logic      ready;
   value_type common_value;
   logic      found;
   logic      last;
   logic      overflow;

   modport source (output valid, output common_value, output found, output last,
                   output overflow, input ready);
   modport sink (input valid, input common_value, input found, input last,
                 input overflow, output ready);
endinterface

// ===== sv/ssi_set_ram.sv =====
module ssi_set_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ssi_join_ctrl.sv =====
`include "sorted_set_intersection_unit_assert.svh"

module ssi_join_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   ssi_req_if.sink                  req,
   input  logic                     out_free,
   input  ssi_pkg::value_type       rd_first_data,
   input  ssi_pkg::value_type       rd_second_data,
   output ssi_pkg::ram_ctrl_type    first_ram,
   output ssi_pkg::ram_ctrl_type    second_ram,
   output ssi_pkg::result_load_type result
);
   import ssi_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   cnt_type    cnt1_ff, cnt1_in;
   cnt_type    cnt2_ff, cnt2_in;
   cnt_type    i_ff, i_in;
   cnt_type    j_ff, j_in;
   num_type    n_ff, n_in;
   logic       drop_ff, drop_in;
   logic       pend_valid_ff, pend_valid_in;
   value_type  pend_value_ff, pend_value_in;

   logic accept;
   logic bounds_ok;

   assign accept    = req.valid && req.ready;
   assign bounds_ok = (i_ff < cnt1_ff) && (j_ff < cnt2_ff) && (n_ff < NUM_W'(OUT_LIMIT));

   always_comb begin
      state_in      = state_ff;
      cnt1_in       = cnt1_ff;
      cnt2_in       = cnt2_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      drop_in       = drop_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      req.ready     = (state_ff == ST_IDLE);
      result        = '0;
      first_ram     = '0;
      second_ram    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.operation)
                  OP_LOAD_FIRST: begin
                     if (cnt1_ff < CNT_W'(SET_DEPTH)) begin
                        first_ram.wr_en = 1'b1;
                        cnt1_in         = cnt1_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OP_LOAD_SECOND: begin
                     if (cnt2_ff < CNT_W'(SET_DEPTH)) begin
                        second_ram.wr_en = 1'b1;
                        cnt2_in          = cnt2_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OP_RUN: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // Read data always belongs to the current heads i_ff and j_ff.
            if (!bounds_ok) begin
               state_in = ST_FINISH;
            end else if (rd_first_data < rd_second_data) begin
               i_in = i_ff + CNT_W'(1);
            end else if (rd_second_data < rd_first_data) begin
               j_in = j_ff + CNT_W'(1);
            end else if (!pend_valid_ff || out_free) begin
               // The previous match is known not to be the last one now.
               if (pend_valid_ff) begin
                  result.load              = 1'b1;
                  result.data.common_value = pend_value_ff;
                  result.data.found        = 1'b1;
                  result.data.last         = 1'b0;
                  result.data.overflow     = drop_ff;
               end
               pend_value_in = rd_first_data;
               pend_valid_in = 1'b1;
               n_in          = n_ff + NUM_W'(1);
               i_in          = i_ff + CNT_W'(1);
               j_in          = j_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               result.load              = 1'b1;
               result.data.common_value = pend_valid_ff ? pend_value_ff : '0;
               result.data.found        = pend_valid_ff;
               result.data.last         = 1'b1;
               result.data.overflow     = drop_ff;
               cnt1_in                  = '0;
               cnt2_in                  = '0;
               i_in                     = '0;
               j_in                     = '0;
               n_in                     = '0;
               drop_in                  = 1'b0;
               pend_valid_in            = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      first_ram.wr_addr  = cnt1_ff[ADDR_W-1:0];
      first_ram.wr_data  = req.value;
      first_ram.rd_addr  = i_in[ADDR_W-1:0];
      second_ram.wr_addr = cnt2_ff[ADDR_W-1:0];
      second_ram.wr_data = req.value;
      second_ram.rd_addr = j_in[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt1_ff       <= '0;
         cnt2_ff       <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         n_ff          <= '0;
         drop_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt1_ff       <= cnt1_in;
         cnt2_ff       <= cnt2_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         n_ff          <= n_in;
         drop_ff       <= drop_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_value_ff <= pend_value_in;
   end

   `SSI_ASSERT(count_in_range, (cnt1_ff <= CNT_W'(SET_DEPTH)) && (cnt2_ff <= CNT_W'(SET_DEPTH)))
   `SSI_ASSERT(result_only_when_free, result.load |-> out_free)
   `SSI_ASSERT(miss_is_last, (result.load && !result.data.found) |-> result.data.last)
   `SSI_ASSERT(run_empties_sets, (state_ff == ST_FINISH && out_free) |=> (cnt1_ff == '0 && cnt2_ff == '0 && !drop_ff))
   `SSI_ASSERT(pending_counted, pend_valid_ff |-> (n_ff != '0))

endmodule

// ===== sv/sorted_set_intersection_unit.sv =====
// Sorted set intersection unit. Load beats (operation 0 or 1) append one
// signed value to the first or second buffer of SET_DEPTH entries; a load
// into a full buffer is dropped and sets the overflow flag.
// A run beat (operation 2) merge-joins the two buffers and returns each common
// value in order, the final one marked last, or a single beat with found low
// when nothing matches; every result of a run carries the overflow flag, and
// the run then empties both buffers and clears the flag. A run is accepted,
// then takes one join step at a time, where a step advances the first head,
// the second head or both, so fewer steps than the sum of the two fill counts
// unless both buffers are empty; then it sees that a buffer is used up and
// hands over the final beat. A stall of the result channel holds the run. The
// join loop reads one entry of each buffer memory per cycle through their
// single read ports, except while a match waits for the output register.
// No request is taken until the run is over. Code 3 is accepted and ignored.
module sorted_set_intersection_unit (
   input logic        clock,
   input logic        reset,
   ssi_req_if.sink    req,
   ssi_rsp_if.source  rsp
);
   import ssi_pkg::*;

   ram_ctrl_type    first_ram;
   ram_ctrl_type    second_ram;
   result_load_type result;
   logic [VALUE_W-1:0] rd_first_raw;
   logic [VALUE_W-1:0] rd_second_raw;
   value_type       rd_first_data;
   value_type       rd_second_data;
   logic            out_free;

   // Output register: one result beat waits here while the join continues.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // The first buffer memory.
   ssi_set_ram #(
      .DEPTH  (SET_DEPTH),
      .WIDTH  (VALUE_W),
      .ADDR_W (ADDR_W)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (first_ram.wr_en),
      .wr_addr (first_ram.wr_addr),
      .wr_data (first_ram.wr_data),
      .rd_addr (first_ram.rd_addr),
      .rd_data (rd_first_raw)
   );

   // The second buffer memory.
   ssi_set_ram #(
      .DEPTH  (SET_DEPTH),
      .WIDTH  (VALUE_W),
      .ADDR_W (ADDR_W)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (second_ram.wr_en),
      .wr_addr (second_ram.wr_addr),
      .wr_data (second_ram.wr_data),
      .rd_addr (second_ram.rd_addr),
      .rd_data (rd_second_raw)
   );

   assign rd_first_data  = value_type'(rd_first_raw);
   assign rd_second_data = value_type'(rd_second_raw);

   // The controller owns the fill counts, the join heads and the held match.
   ssi_join_ctrl u_join_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .out_free       (out_free),
      .rd_first_data  (rd_first_data),
      .rd_second_data (rd_second_data),
      .first_ram      (first_ram),
      .second_ram     (second_ram),
      .result         (result)
   );

   // The register can take a new beat when it is empty or being emptied now.
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.data;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.common_value = rsp_data_ff.common_value;
   assign rsp.found        = rsp_data_ff.found;
   assign rsp.last         = rsp_data_ff.last;
   assign rsp.overflow     = rsp_data_ff.overflow;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for the sorted set intersection unit.
//
// A sender process loads ascending sequences into the two buffers and issues
// run beats. A predictor of the merge join, kept in this file, turns every
// accepted request beat into the result beats the unit must return. Those
// beats wait in a queue until the checker pops them. The receiver side stalls
// at random, and once holds off for a long stretch so that the unit backs up
// into its request channel.
module testbench;
   import ssi_pkg::*;

   // Code 3 has no name in the package; the unit must swallow it.
   localparam op_type    OP_UNUSED   = 2'd3;
   localparam value_type VALUE_MIN   = {1'b1, {(VALUE_W - 1){1'b0}}};
   localparam value_type VALUE_MAX   = {1'b0, {(VALUE_W - 1){1'b1}}};
   localparam int        ITEM_TARGET = 370;
   localparam int        HOLD_CYCLES = 400;
   localparam int        STALL_LIMIT = 5000;
   localparam int        PRINT_LIMIT = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssi_req_if req_if ();
   ssi_rsp_if rsp_if ();

   sorted_set_intersection_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: a private copy of both buffers, their fill levels and
   // the sticky drop flag, updated at every accepted request beat.
   value_type  first_entries [SET_DEPTH];
   value_type  second_entries[SET_DEPTH];
   int         first_fill;
   int         second_fill;
   logic       drop_seen;
   result_type pending_results[$];

   int   mismatch_count = 0;
   int   beats_sent     = 0;
   int   quiet_cycles   = 0;
   // While steady is set neither side inserts idle cycles.
   logic steady         = 1'b0;
   // Each increment of hold_asked starts one long receiver hold-off.
   int   hold_asked     = 0;
   int   hold_seen      = 0;
   int   hold_left      = 0;

   task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                  input logic signed [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   // Merge join of the two buffers, stepping past the smaller head and
   // emitting on equal heads; a run always clears both buffers and the flag.
   function automatic void predict_intersection(input op_type op, input value_type v);
      int         i;
      int         j;
      int         n;
      result_type beat;
      i = 0;
      j = 0;
      n = 0;
      case (op)
         OP_LOAD_FIRST: begin
            if (first_fill < SET_DEPTH) begin
               first_entries[first_fill] = v;
               first_fill++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         OP_LOAD_SECOND: begin
            if (second_fill < SET_DEPTH) begin
               second_entries[second_fill] = v;
               second_fill++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         OP_RUN: begin
            while (i < first_fill && j < second_fill && n < OUT_LIMIT) begin
               if (first_entries[i] < second_entries[j]) begin
                  i++;
               end else if (second_entries[j] < first_entries[i]) begin
                  j++;
               end else begin
                  beat.common_value = first_entries[i];
                  beat.found        = 1'b1;
                  beat.last         = 1'b0;
                  beat.overflow     = drop_seen;
                  pending_results.push_back(beat);
                  n++;
                  i++;
                  j++;
               end
            end
            if (n == 0) begin
               beat.common_value = '0;
               beat.found        = 1'b0;
               beat.last         = 1'b1;
               beat.overflow     = drop_seen;
               pending_results.push_back(beat);
            end else begin
               beat      = pending_results.pop_back();
               beat.last = 1'b1;
               pending_results.push_back(beat);
            end
            first_fill  = 0;
            second_fill = 0;
            drop_seen   = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // Offers one beat, with random idle cycles ahead of it, and returns at the
   // edge that accepts it. Valid is left high so that back-to-back beats do
   // not drop it for a step; the next call or a wait for results lowers it.
   task automatic send_beat(input op_type op, input value_type v);
      if (!steady) begin
         while ($urandom_range(99, 0) < 33) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.value     <= v;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      predict_intersection(op, v);
      if (op != OP_UNUSED) begin
         beats_sent++;
      end
   endtask

   // Withdraws the request and waits until nothing more is expected.
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_results.size() != 0);
   endtask

   // Loads both sequences, interleaving the two buffers at random and now and
   // then slipping in an unused code, then issues the run.
   task automatic send_sets(input value_type first_q[$], input value_type second_q[$]);
      int i;
      int j;
      i = 0;
      j = 0;
      while (i < first_q.size() || j < second_q.size()) begin
         if (j >= second_q.size() || (i < first_q.size() && $urandom_range(1, 0) == 1)) begin
            send_beat(OP_LOAD_FIRST, first_q[i]);
            i++;
         end else begin
            send_beat(OP_LOAD_SECOND, second_q[j]);
            j++;
         end
         if ($urandom_range(15, 0) == 0) begin
            send_beat(OP_UNUSED, value_type'($urandom));
         end
      end
      send_beat(OP_RUN, value_type'($urandom));
   endtask

   // A run on two empty buffers must give the single not-found beat.
   task automatic test_empty_run();
      send_beat(OP_RUN, '0);
      send_beat(OP_RUN, '1);
   endtask

   // The most negative and most positive values both match, which tests
   // that the join compares as signed numbers.
   task automatic test_extreme_values();
      send_beat(OP_LOAD_FIRST, VALUE_MIN);
      send_beat(OP_LOAD_FIRST, -1);
      send_beat(OP_LOAD_FIRST, 0);
      send_beat(OP_LOAD_SECOND, VALUE_MIN);
      send_beat(OP_LOAD_SECOND, 0);
      send_beat(OP_LOAD_FIRST, 1);
      send_beat(OP_LOAD_SECOND, 5);
      send_beat(OP_LOAD_FIRST, VALUE_MAX);
      send_beat(OP_LOAD_SECOND, VALUE_MAX);
      send_beat(OP_RUN, VALUE_MAX);
   endtask

   // The unused code must leave both buffers untouched, whatever it carries.
   task automatic test_unused_code();
      send_beat(OP_LOAD_FIRST, 7);
      send_beat(OP_UNUSED, 7);
      send_beat(OP_LOAD_SECOND, 7);
      send_beat(OP_UNUSED, '1);
      send_beat(OP_RUN, '1);
   endtask

   // Unsorted content is joined by the same stepping rule without a check;
   // here the 3 in the first buffer is stepped past and never matched.
   task automatic test_unsorted_input();
      send_beat(OP_LOAD_FIRST, 5);
      send_beat(OP_LOAD_FIRST, 3);
      send_beat(OP_LOAD_FIRST, 7);
      send_beat(OP_LOAD_SECOND, 3);
      send_beat(OP_LOAD_SECOND, 7);
      send_beat(OP_RUN, 0);
   endtask

   // Both buffers are filled past their depth, so one load on each side is
   // dropped and all of the 32 results carry the overflow flag. The receiver
   // holds off meanwhile, and the next sequence is offered while those
   // results are still held back, so the unit has to stall its input.
   task automatic test_full_buffers_held();
      value_type first_q[$];
      value_type second_q[$];
      hold_asked++;
      for (int k = 0; k <= SET_DEPTH; k++) begin
         first_q.push_back(value_type'(k * 3 - 40));
         second_q.push_back(value_type'(k * 3 - 40));
      end
      send_sets(first_q, second_q);
      first_q.delete();
      second_q.delete();
      first_q.push_back(4);
      first_q.push_back(9);
      second_q.push_back(9);
      send_sets(first_q, second_q);
      wait_for_results();
   endtask

   // Random ascending sequences drawn from one pool, each pool value going to
   // the first buffer, the second or both. Gaps range from dense (with
   // repeats) to sparse, and some sequences start at the bottom of the range
   // or end at the top. A few are unsorted or pure noise, some overfill a
   // buffer, and a stretch in the middle runs with no idling at all.
   task automatic test_random_sets();
      value_type first_q[$];
      value_type second_q[$];
      value_type swap_value;
      longint    level;
      longint    gap_max;
      int        pool_len;
      int        pick;
      int        a;
      int        b;
      int        seq;
      seq = 0;
      while (beats_sent < ITEM_TARGET) begin
         first_q.delete();
         second_q.delete();
         steady   = (seq >= 12 && seq < 24);
         pool_len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 0);
         if ($urandom_range(9, 0) == 0) begin
            for (int k = 0; k < $urandom_range(6, 1); k++) begin
               first_q.push_back(value_type'($urandom));
               second_q.push_back(value_type'($urandom));
            end
         end else begin
            case ($urandom_range(2, 0))
               0: gap_max = 2;
               1: gap_max = 1000;
               default: gap_max = 64'd1 << 26;
            endcase
            case ($urandom_range(3, 0))
               0: level = VALUE_MIN;
               1: level = longint'(VALUE_MAX) - gap_max * pool_len;
               default: level = longint'(value_type'($urandom));
            endcase
            for (int k = 0; k < pool_len; k++) begin
               level = level + $urandom_range(gap_max, 0);
               if (level > longint'(VALUE_MAX)) begin
                  level = VALUE_MAX;
               end
               pick = $urandom_range(3, 0);
               if (pick != 1) begin
                  first_q.push_back(value_type'(level));
               end
               if (pick != 0) begin
                  second_q.push_back(value_type'(level));
               end
            end
            if ($urandom_range(7, 0) == 0 && first_q.size() > 1) begin
               a              = $urandom_range(first_q.size() - 1, 0);
               b              = $urandom_range(first_q.size() - 1, 0);
               swap_value     = first_q[a];
               first_q[a]     = first_q[b];
               first_q[b]     = swap_value;
            end
         end
         send_sets(first_q, second_q);
         // Now and then the sender waits for the run to finish completely.
         if ($urandom_range(5, 0) == 0) begin
            wait_for_results();
         end
         seq++;
      end
      steady = 1'b0;
   endtask

   // Receiver: random stalls, none while steady is set, and a long hold-off
   // counted here whenever a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
      end else if (hold_asked != hold_seen) begin
         hold_seen    <= hold_asked;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99, 0) >= 33);
      end
   end

   // Every result beat is compared field by field with the oldest
   // expectation; a beat with nothing waiting is a failure of its own.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_if.common_value, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.common_value !== want.common_value) begin
               report_mismatch("common_value", rsp_if.common_value, want.common_value);
            end
            if (rsp_if.found !== want.found) begin
               report_mismatch("found", rsp_if.found, want.found);
            end
            if (rsp_if.last !== want.last) begin
               report_mismatch("last", rsp_if.last, want.last);
            end
            if (rsp_if.overflow !== want.overflow) begin
               report_mismatch("overflow", rsp_if.overflow, want.overflow);
            end
         end
      end
   end

   // Watchdog: a run of cycles in which neither channel moves a beat means
   // the unit has hung.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.operation = OP_LOAD_FIRST;
      req_if.value     = '0;
      rsp_if.ready     = 1'b0;
      first_fill       = 0;
      second_fill      = 0;
      drop_seen        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_run();
      test_extreme_values();
      test_unused_code();
      test_unsorted_input();
      wait_for_results();
      test_full_buffers_held();
      test_random_sets();

      wait_for_results();
      // Allow for a run that might still emit beats nobody predicted.
      repeat (2 * SET_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
